[src/vt_pkg.sv]
package vt_pkg;

    localparam int FIELD_BITS = 32;
    localparam int COEF_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_BITS = 4;
    localparam int CFG_BITS   = 64;
    localparam int PROJ_SCALE = 800;
    localparam int SCALE_BITS = 10;
    localparam int NEAR_LIMIT = 32768;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] in_x;
        logic signed [FIELD_BITS-1:0] in_y;
        logic signed [FIELD_BITS-1:0] in_z;
        logic signed [FIELD_BITS-1:0] in_w;
    } t_vtx_in;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] out_x;
        logic signed [FIELD_BITS-1:0] out_y;
        logic signed [FIELD_BITS-1:0] out_z;
        logic signed [FIELD_BITS-1:0] out_w;
        logic                         in_front;
    } t_vtx_out;

endpackage

[src/vt_mac.sv]
module vt_mac import vt_pkg::*; #(
    parameter int COORD_BITS = 32,
    parameter int SW = COORD_BITS + FRAC_BITS + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  t_vtx_in                     i_vtx,
    input  logic signed [COEF_BITS-1:0] i_coef [16],
    output logic                        o_valid,
    output logic signed [SW-1:0]        o_sum [4]
);

    localparam int PW = COEF_BITS + COORD_BITS;
    localparam int HW = PW - FRAC_BITS;

    logic signed [COORD_BITS-1:0] v [4];
    logic signed [PW-1:0]         r_prod [16];
    logic signed [PW-1:0]         n_prod [16];
    logic signed [SW-1:0]         r_sum [4];
    logic signed [SW-1:0]         n_sum [4];
    logic                         r_v1;
    logic                         r_v2;

    assign v[0] = i_vtx.in_x[COORD_BITS-1:0];
    assign v[1] = i_vtx.in_y[COORD_BITS-1:0];
    assign v[2] = i_vtx.in_z[COORD_BITS-1:0];
    assign v[3] = i_vtx.in_w[COORD_BITS-1:0];

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            n_prod[k] = PW'(i_coef[k]) * PW'(v[k % 4]);
        end
    end

    always_comb begin
        logic signed [HW-1:0] sh;
        for (int r = 0; r < 4; r++) begin
            n_sum[r] = '0;
            for (int c = 0; c < 4; c++) begin
                sh = HW'(r_prod[r*4+c] >>> FRAC_BITS);
                n_sum[r] = n_sum[r] + SW'(sh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_sum  <= n_sum;
        end
    end

    assign o_valid = r_v2;
    assign o_sum   = r_sum;

endmodule

[src/vt_div.sv]
module vt_div import vt_pkg::*; #(
    parameter int N  = 60,
    parameter int M  = 50,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [N-1:0]  i_dvd [2],
    input  logic [M-1:0]  i_dvs,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [N-1:0]  o_quo [2],
    output logic [PW-1:0] o_pay
);

    logic [M-1:0]  r_rem [N][2];
    logic [N-1:0]  r_dvd [N][2];
    logic [N-1:0]  r_quo [N][2];
    logic [M-1:0]  r_dvs [N];
    logic [PW-1:0] r_pay [N];
    logic          r_v   [N];

    genvar k, l;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [M-1:0]  p_dvs;
            logic [PW-1:0] p_pay;
            logic          p_v;
            if (k == 0) begin : g_first
                assign p_dvs = i_dvs;
                assign p_pay = i_pay;
                assign p_v   = i_valid;
            end else begin : g_next
                assign p_dvs = r_dvs[k-1];
                assign p_pay = r_pay[k-1];
                assign p_v   = r_v[k-1];
            end

            for (l = 0; l < 2; l++) begin : g_lane
                logic [M-1:0] p_rem;
                logic [N-1:0] p_dvd;
                logic [N-1:0] p_quo;
                logic [M:0]   trial;
                logic [M:0]   diff;
                if (k == 0) begin : g_first
                    assign p_rem = '0;
                    assign p_dvd = i_dvd[l];
                    assign p_quo = '0;
                end else begin : g_next
                    assign p_rem = r_rem[k-1][l];
                    assign p_dvd = r_dvd[k-1][l];
                    assign p_quo = r_quo[k-1][l];
                end
                assign trial = {p_rem, p_dvd[N-1]};
                assign diff  = trial - {1'b0, p_dvs};

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_dvd[k][l] <= {p_dvd[N-2:0], 1'b0};
                        if (!diff[M]) begin
                            r_rem[k][l] <= diff[M-1:0];
                            r_quo[k][l] <= {p_quo[N-2:0], 1'b1};
                        end else begin
                            r_rem[k][l] <= trial[M-1:0];
                            r_quo[k][l] <= {p_quo[N-2:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dvs[k] <= p_dvs;
                    r_pay[k] <= p_pay;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= p_v;
                end
            end
        end
    endgenerate

    assign o_valid  = r_v[N-1];
    assign o_quo[0] = r_quo[N-1][0];
    assign o_quo[1] = r_quo[N-1][1];
    assign o_pay    = r_pay[N-1];

endmodule

[src/vertex_transform_project.sv]
// Transforms one homogeneous Q16.16 vertex per clock, while the output is not stalled, by a
// configurable 4x4 matrix and, when the transformed z exceeds one half, scales x and y by
// 800/z. The pipeline's depth is set mostly by the restoring divider that resolves one
// quotient bit per stage, and it accepts one item every cycle unless stalled. A stall on
// the output holds the whole pipeline in place. Matrix registers may only be written while
// no item is in flight.
module vertex_transform_project import vt_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_vtx_in                 i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_vtx_out                o_out,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    localparam int SW  = COORD_BITS + FRAC_BITS + 2;
    localparam int DW  = SW + SCALE_BITS;
    localparam int PAY = 3 + 4 * SW;
    localparam int QW  = DW + 1;

    logic                        en;
    logic [CFG_BITS-1:0]         r_cfg [NUM_REGS];
    logic signed [COEF_BITS-1:0] coef [16];
    logic                        mac_valid;
    logic signed [SW-1:0]        sum [4];
    logic                        r_s3_valid;
    logic [DW-1:0]               r_mag [2];
    logic [SW-1:0]               r_dvs;
    logic [PAY-1:0]              r_pay;
    logic signed [DW-1:0]        sx;
    logic signed [DW-1:0]        sy;
    logic                        div_valid;
    logic [DW-1:0]               quo [2];
    logic [PAY-1:0]              pay;
    logic                        f_front;
    logic                        f_negx;
    logic                        f_negy;
    logic signed [SW-1:0]        f_t [4];
    logic signed [QW-1:0]        vx;
    logic signed [QW-1:0]        vy;
    logic                        r_out_valid;
    t_vtx_out                    r_out;
    t_vtx_out                    n_out;

    function automatic logic signed [FIELD_BITS-1:0] sat(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] hi;
        logic signed [QW-1:0] lo;
        logic signed [QW-1:0] c;
        hi = QW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
        lo = -hi - QW'(1);
        c  = v;
        if (v > hi) c = hi;
        if (v < lo) c = lo;
        return FIELD_BITS'(c);
    endfunction

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= CFG_BITS'(65536);
            r_cfg[1] <= '0;
            r_cfg[2] <= CFG_BITS'(1) << 48;
            r_cfg[3] <= '0;
            r_cfg[4] <= '0;
            r_cfg[5] <= CFG_BITS'(65536);
            r_cfg[6] <= '0;
            r_cfg[7] <= CFG_BITS'(1) << 48;
        end else if (i_cfg_valid && o_cfg_ready && i_cfg_index < CFG_IDX_BITS'(NUM_REGS)) begin
            r_cfg[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                coef[r*4+c] = r_cfg[r*2 + c/2][(c%2)*COEF_BITS +: COEF_BITS];
            end
        end
    end

    vt_mac #(.COORD_BITS(COORD_BITS), .SW(SW)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_vtx   (i_in),
        .i_coef  (coef),
        .o_valid (mac_valid),
        .o_sum   (sum)
    );

    assign sx = DW'(sum[0]) * DW'(PROJ_SCALE);
    assign sy = DW'(sum[1]) * DW'(PROJ_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= mac_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag[0] <= sx[DW-1] ? DW'(-sx) : DW'(sx);
            r_mag[1] <= sy[DW-1] ? DW'(-sy) : DW'(sy);
            r_dvs    <= sum[2];
            r_pay    <= {sum[2] > SW'(NEAR_LIMIT), sx[DW-1], sy[DW-1],
                         sum[0], sum[1], sum[2], sum[3]};
        end
    end

    vt_div #(.N(DW), .M(SW), .PW(PAY)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_valid),
        .i_dvd   (r_mag),
        .i_dvs   (r_dvs),
        .i_pay   (r_pay),
        .o_valid (div_valid),
        .o_quo   (quo),
        .o_pay   (pay)
    );

    assign {f_front, f_negx, f_negy, f_t[0], f_t[1], f_t[2], f_t[3]} = pay;

    always_comb begin
        if (f_front) begin
            vx = f_negx ? -QW'(quo[0]) : QW'(quo[0]);
            vy = f_negy ? -QW'(quo[1]) : QW'(quo[1]);
        end else begin
            vx = QW'(f_t[0]);
            vy = QW'(f_t[1]);
        end
        n_out.out_x    = sat(vx);
        n_out.out_y    = sat(vy);
        n_out.out_z    = sat(QW'(f_t[2]));
        n_out.out_w    = sat(QW'(f_t[3]));
        n_out.in_front = f_front;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_front_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.in_front |-> !o_out.out_z[FIELD_BITS-1] && o_out.out_z != '0)
        else $error("in-front item with non-positive z");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule
